/* rtl/ccss_pkg.sv */
// Shared types, constants and month-length function for the calendar second step.
package ccss_pkg;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } req_word_type;

   typedef struct packed {
      logic [15:0] next_year;
      logic [3:0]  next_month;
      logic [4:0]  next_day;
      logic [4:0]  next_hour;
      logic [5:0]  next_minute;
      logic [5:0]  next_second;
      logic        bad_input;
   } rsp_word_type;

   // per-item flags carried down the pipe next to the word
   typedef struct packed {
      logic bad;        // some field out of range
      logic sec_wrap;   // second is at its last value
      logic min_wrap;   // minute is at its last value
      logic hour_wrap;  // hour is at its last value
      logic last_day;   // day is the last of its month
   } flags_type;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] DAY_FIRST = 5'd1;
   localparam logic [4:0] HOUR_MAX  = 5'd23;
   localparam logic [5:0] MIN_MAX   = 6'd59;
   localparam logic [5:0] SEC_MAX   = 6'd59;

   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_FEB   = 5'd28;
   localparam logic [4:0] DAYS_LEAP  = 5'd29;

   // year / 25 as (year * DIV25_MUL) >> DIV25_SHIFT, exact for all 16-bit years
   localparam logic [4:0]  DIV25       = 5'd25;
   localparam logic [16:0] DIV25_MUL   = 17'd83887;
   localparam int          DIV25_SHIFT = 21;
   localparam int          QUOT_W      = 12;
   localparam int          PROD_W      = 33;

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         MONTH_FEB: begin
            days = leap ? DAYS_LEAP : DAYS_FEB;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            days = DAYS_SHORT;
         end
         default: begin
            days = DAYS_LONG;
         end
      endcase
      return days;
   endfunction

endpackage

/* rtl/calendar_clock_second_step.sv */
// Top level: one-second increment of a Gregorian date and time, three-stage pipeline.
//
// Give a date and time on req_word with start high; the same date and time one
// second later appears on rsp_word from the result register, marked by a one-cycle
// rsp_valid. busy never rises, so a new word may be started every cycle and
// results come out in order at that same rate; the receiver must take each
// result in the cycle it is shown. The three stages are: range checks plus the
// year/25 product, then the leap rule and month length, then the carry chain
// into the result register. A word with a field out of range (month outside
// 1..12, day 0 or past the month's end, hour over 23, minute or second over 59)
// comes back unchanged with bad_input set. Year 65535 rolls over to year 0.
module calendar_clock_second_step import ccss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   logic              s1_valid, s2_valid;
   req_word_type      s1_word, s2_word;
   flags_type         s1_flags, s2_flags;
   logic [QUOT_W-1:0] s1_quot;
   logic              accept;

   // every stage advances every cycle, nothing ever waits
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // stage 1: screen fields, start the year/25 divide
   ccss_screen u_screen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (req_word),
      .out_valid (s1_valid),
      .out_word  (s1_word),
      .out_flags (s1_flags),
      .out_quot  (s1_quot)
   );

   // stage 2: leap year and month length
   ccss_leap u_leap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_word   (s1_word),
      .in_flags  (s1_flags),
      .in_quot   (s1_quot),
      .out_valid (s2_valid),
      .out_word  (s2_word),
      .out_flags (s2_flags)
   );

   // stage 3: carries and result register
   ccss_advance u_advance (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_word   (s2_word),
      .in_flags  (s2_flags),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

   // a result only ever follows a started word
   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without a started word");

   // a rejected word comes back untouched
   a_bad_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.bad_input |->
         rsp_word.next_year == $past(req_word.year, 3) &&
         rsp_word.next_month == $past(req_word.month, 3) &&
         rsp_word.next_day == $past(req_word.day, 3) &&
         rsp_word.next_hour == $past(req_word.hour, 3) &&
         rsp_word.next_minute == $past(req_word.minute, 3) &&
         rsp_word.next_second == $past(req_word.second, 3))
      else $error("bad word not echoed");

   // no seconds rollover means minute, hour and day are unchanged
   a_no_carry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.bad_input && rsp_word.next_second != 6'd0 |->
         rsp_word.next_minute == $past(req_word.minute, 3) &&
         rsp_word.next_hour == $past(req_word.hour, 3) &&
         rsp_word.next_day == $past(req_word.day, 3))
      else $error("carry without seconds rollover");

endmodule

/* rtl/ccss_screen.sv */
// Stage 1: field range checks, rollover flags and the year / 25 product.
module ccss_screen import ccss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_word_type in_word,
   output logic         out_valid,
   output req_word_type out_word,
   output flags_type    out_flags,
   output logic [QUOT_W-1:0] out_quot
);

   logic              valid_ff;
   req_word_type      word_ff;
   flags_type         flags_ff, flags_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [PROD_W-1:0] prod;

   always_comb begin
      prod = PROD_W'(in_word.year) * PROD_W'(DIV25_MUL);
      quot_in = prod[DIV25_SHIFT +: QUOT_W];

      flags_in           = '0;
      flags_in.bad       = (in_word.month < MONTH_JAN) || (in_word.month > MONTH_DEC) ||
                           (in_word.day < DAY_FIRST) || (in_word.hour > HOUR_MAX) ||
                           (in_word.minute > MIN_MAX) || (in_word.second > SEC_MAX);
      flags_in.sec_wrap  = (in_word.second == SEC_MAX);
      flags_in.min_wrap  = (in_word.minute == MIN_MAX);
      flags_in.hour_wrap = (in_word.hour == HOUR_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff  <= in_word;
      flags_ff <= flags_in;
      quot_ff  <= quot_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_flags = flags_ff;
   assign out_quot  = quot_ff;

endmodule

/* rtl/ccss_leap.sv */
// Stage 2: leap year, month length, day range check and last-day flag.
module ccss_leap import ccss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_word_type in_word,
   input  flags_type    in_flags,
   input  logic [QUOT_W-1:0] in_quot,
   output logic         out_valid,
   output req_word_type out_word,
   output flags_type    out_flags
);

   logic         valid_ff;
   req_word_type word_ff;
   flags_type    flags_ff, flags_in;
   logic [15:0]  rem;
   logic         div25;
   logic         leap;
   logic [4:0]   days;

   always_comb begin
      rem   = in_word.year - 16'(in_quot) * 16'(DIV25);
      div25 = (rem == 16'd0);
      // div by 100 = div by 4 and 25; div by 400 = div by 16 and 25
      leap  = (in_word.year[1:0] == 2'd0 && !div25) || (in_word.year[3:0] == 4'd0 && div25);
      days  = month_days(in_word.month, leap);

      flags_in          = in_flags;
      flags_in.bad      = in_flags.bad || (in_word.day > days);
      flags_in.last_day = (in_word.day == days);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff  <= in_word;
      flags_ff <= flags_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_flags = flags_ff;

endmodule

/* rtl/ccss_advance.sv */
// Stage 3: carry chain through seconds, minutes, hours and the date; result register.
module ccss_advance import ccss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_word_type in_word,
   input  flags_type    in_flags,
   output logic         out_valid,
   output rsp_word_type out_word
);

   logic         valid_ff;
   rsp_word_type word_ff, word_in;
   logic         carry_min, carry_hour, carry_day;

   always_comb begin
      carry_min  = in_flags.sec_wrap;
      carry_hour = carry_min && in_flags.min_wrap;
      carry_day  = carry_hour && in_flags.hour_wrap;

      word_in.next_year   = in_word.year;
      word_in.next_month  = in_word.month;
      word_in.next_day    = in_word.day;
      word_in.next_hour   = in_word.hour;
      word_in.next_minute = in_word.minute;
      word_in.next_second = in_word.second;
      word_in.bad_input   = in_flags.bad;

      if (!in_flags.bad) begin
         word_in.next_second = in_flags.sec_wrap ? 6'd0 : in_word.second + 6'd1;
         if (carry_min) begin
            word_in.next_minute = in_flags.min_wrap ? 6'd0 : in_word.minute + 6'd1;
         end
         if (carry_hour) begin
            word_in.next_hour = in_flags.hour_wrap ? 5'd0 : in_word.hour + 5'd1;
         end
         if (carry_day) begin
            if (!in_flags.last_day) begin
               word_in.next_day = in_word.day + 5'd1;
            end else if (in_word.month == MONTH_DEC) begin
               word_in.next_day   = DAY_FIRST;
               word_in.next_month = MONTH_JAN;
               word_in.next_year  = in_word.year + 16'd1;
            end else begin
               word_in.next_day   = DAY_FIRST;
               word_in.next_month = in_word.month + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
